[design/fba_pkg.sv]
// Shared types, constants and helpers for the frame bitmap allocator.
// No dependencies; imported by frame_bitmap_allocator.
package fba_pkg;

    localparam int FRAME_COUNT_DEF = 32768;
    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int ONE_MIB_ADDR    = 32'h0010_0000;

    localparam int FRAME_W = 15;
    localparam int CFG_W   = 16;

    // request kinds
    localparam logic [1:0] REQ_MARK  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_CHECK = 2'd3;

    // configuration register indexes
    localparam logic CFG_KERNEL_FIRST = 1'b0;
    localparam logic CFG_KERNEL_END   = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FRAME_W-1:0] frame_number;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [FRAME_W-1:0] granted_frame;
        logic               is_available;
    } resp_t;

    // index of the lowest set bit of a byte, zero for an empty byte
    function automatic logic [2:0] lowest_set(input logic [7:0] v);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

endpackage

[design/fba_bitmap_ram.sv]
// Availability bitmap storage: one write port, one read port, registered read.
// Depends on nothing but its parameters.
module fba_bitmap_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/frame_bitmap_allocator.sv]
// Frame bitmap allocator top level: request sequencer, hint, config registers.
// Depends on fba_pkg and fba_bitmap_ram.
//
// One availability bit per page frame lives in a byte-wide RAM. After reset the
// block sweeps the RAM to zero, one byte per cycle, over FRAME_COUNT/8 bytes
// (4096 at the default size), and takes no request until the sweep ends; config
// writes are taken throughout. For mark, free and check the accepting cycle
// issues the byte read and the next cycle modifies, writes back and posts the
// result. Allocate examines bitmap bytes from the hint up to the first nonzero
// byte (or to the end of the map), one byte per RAM read. A request may be
// accepted while the previous result waits at the output; if that result is
// still not taken when the new one is ready, the new one waits in the hold
// register until it is.
module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output resp_t            out_item,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int MAP_BYTES   = FRAME_COUNT / 8;
    localparam int AW          = $clog2(MAP_BYTES);
    localparam bit MIB_ALIGNED = (ONE_MIB_ADDR % PAGE_BYTES) == 0;
    localparam int MIB_FRAME   = ONE_MIB_ADDR / PAGE_BYTES;
    localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WORK  = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    cur_addr_reg;
    logic [AW-1:0]    hint_reg;
    req_t             req_reg;
    resp_t            hold_reg;
    resp_t            out_reg;
    logic             out_valid_reg;
    logic [CFG_W-1:0] kernel_first_reg;
    logic [CFG_W-1:0] kernel_end_reg;

    logic             accept;
    logic             slot_free;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    logic [AW+11:0]   in_byte_ext;
    logic [AW-1:0]    in_byte;
    logic             in_map;
    logic             reserved;
    logic [2:0]       bit_ix;
    logic [7:0]       bit_mask;
    logic [2:0]       low_k;
    logic             done;
    logic             scan_on;
    logic             work_we;
    logic [7:0]       work_wdata;
    resp_t            res;
    logic [AW+17:0]   grant_ext;

    fba_bitmap_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign in_byte_ext = {{AW{1'b0}}, in_item.frame_number[FRAME_W-1:3]};
    assign in_byte     = in_byte_ext[AW-1:0];

    // classification of the held request's frame
    assign in_map   = 32'(req_reg.frame_number) < 32'(FRAME_COUNT);
    assign reserved = (MIB_ALIGNED && (32'(req_reg.frame_number) == 32'(MIB_FRAME)))
                   || ((16'(req_reg.frame_number) >= kernel_first_reg)
                       && (16'(req_reg.frame_number) < kernel_end_reg));
    assign bit_ix   = req_reg.frame_number[2:0];
    assign bit_mask = 8'b1 << bit_ix;
    assign low_k    = lowest_set(ram_rdata);
    assign grant_ext = {15'b0, cur_addr_reg, low_k};

    always_comb
    begin
        done       = 1'b1;
        work_we    = 1'b0;
        work_wdata = ram_rdata | bit_mask;
        res        = '0;
        case (req_reg.req_type)
            REQ_MARK:
            begin
                work_we = in_map && !reserved;
            end
            REQ_ALLOC:
            begin
                work_wdata = ram_rdata & ~(8'b1 << low_k);
                if (ram_rdata != 8'd0)
                begin
                    work_we           = 1'b1;
                    res.granted_frame = grant_ext[FRAME_W-1:0];
                end
                else if (cur_addr_reg == LAST_BYTE)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    done = 1'b0;
                end
            end
            REQ_FREE:
            begin
                work_we = in_map;
            end
            default:
            begin
                res.is_available = in_map && ram_rdata[bit_ix];
            end
        endcase
    end

    assign scan_on = (state_reg == S_WORK) && !done;

    // RAM port steering: clearing sweep, then request traffic
    always_comb
    begin
        ram_re    = accept || scan_on;
        ram_raddr = cur_addr_reg + AW'(1);
        if (accept)
        begin
            ram_raddr = (in_item.req_type == REQ_ALLOC) ? hint_reg : in_byte;
        end
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 8'd0;
        end
        else
        begin
            ram_we    = (state_reg == S_WORK) && work_we;
            ram_waddr = cur_addr_reg;
            ram_wdata = work_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_BYTE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (done)
                begin
                    state_next = slot_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            hint_reg         <= '0;
            out_valid_reg    <= 1'b0;
            kernel_first_reg <= '0;
            kernel_end_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_KERNEL_FIRST)
                begin
                    kernel_first_reg <= cfg_data;
                end
                else
                begin
                    kernel_end_reg <= cfg_data;
                end
            end
            // advance the hint to the byte that granted a frame
            if ((state_reg == S_WORK) && (req_reg.req_type == REQ_ALLOC)
                && (ram_rdata != 8'd0))
            begin
                hint_reg <= cur_addr_reg;
            end
            if (((state_reg == S_WORK) && done) || (state_reg == S_HOLD))
            begin
                if (slot_free)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= in_item;
            cur_addr_reg <= ram_raddr;
        end
        else if (scan_on)
        begin
            cur_addr_reg <= cur_addr_reg + AW'(1);
        end
        if ((state_reg == S_WORK) && done)
        begin
            if (slot_free)
            begin
                out_reg <= res;
            end
            else
            begin
                hold_reg <= res;
            end
        end
        else if ((state_reg == S_HOLD) && slot_free)
        begin
            out_reg <= hold_reg;
        end
    end

endmodule
